// ----- design/hnbs_pkg.sv -----
// Shared types and constants for the HEVC NAL boundary scanner.
// No dependencies; used by the scanner, the record queue and the top level.
package hnbs_pkg;

   localparam int OUT_W         = 32;
   localparam int ADDR_BITS_DEF = 32;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [5:0]  TYPE_VPS        = 6'd32;
   localparam logic [5:0]  TYPE_LAST_TRAIL = 6'd9;
   localparam logic [23:0] START_CODE      = 24'h000001;
   localparam logic [31:0] WINDOW_RESET    = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [OUT_W-1:0] unit_address;
      logic [OUT_W-1:0] unit_size;
      logic             intra_flag;
      logic [1:0]       region;
      logic             final_rec;
   } record_type;

   // Records produced by one accepted byte: none, one or two, oldest first.
   typedef struct packed {
      logic [1:0] count;
      record_type first;
      record_type second;
   } push_type;

endpackage

// ----- design/hnbs_scan.sv -----
// Start code detector and open-record tracker of the NAL boundary scanner.
// Depends on hnbs_pkg for the record types and NAL type constants.
module hnbs_scan #(
   parameter int ADDR_BITS = hnbs_pkg::ADDR_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              end_of_segment,
   input  logic [1:0]        region,
   output hnbs_pkg::push_type push
);
   import hnbs_pkg::*;

   logic [31:0]          window_ff, window_in;
   logic [ADDR_BITS-1:0] pos_ff, pos_in;
   logic [ADDR_BITS-1:0] pend_addr_ff, pend_addr_in;
   logic                 pend_intra_ff, pend_intra_in;
   logic                 pend_valid_ff, pend_valid_in;

   logic                 start_seen;
   logic [5:0]           nal_type;
   logic                 is_vps;
   logic                 opens;
   logic [ADDR_BITS-1:0] new_addr;
   logic [ADDR_BITS-1:0] seg_len;
   logic [ADDR_BITS-1:0] open_addr;
   logic                 open_intra;
   logic                 open_valid;
   record_type           close_rec;
   record_type           end_rec;
   logic                 close_hit;
   logic                 end_hit;

   always_comb begin
      start_seen = (window_ff[23:0] == START_CODE);
      nal_type   = data_byte[6:1];
      is_vps     = (nal_type == TYPE_VPS);
      opens      = start_seen && (is_vps || (nal_type <= TYPE_LAST_TRAIL));
      // A fourth zero byte ahead of the start code belongs to the unit.
      new_addr   = (window_ff[31:24] == 8'h00) ? pos_ff - ADDR_BITS'(4)
                                               : pos_ff - ADDR_BITS'(3);
      seg_len    = pos_ff + ADDR_BITS'(1);

      close_hit  = accept && opens && pend_valid_ff;
      close_rec.unit_address = OUT_W'(pend_addr_ff);
      close_rec.unit_size    = OUT_W'(ADDR_BITS'(new_addr - pend_addr_ff));
      close_rec.intra_flag   = pend_intra_ff;
      close_rec.region       = region;
      close_rec.final_rec    = 1'b0;

      open_valid = opens || pend_valid_ff;
      open_addr  = opens ? new_addr : pend_addr_ff;
      open_intra = opens ? is_vps : pend_intra_ff;

      end_hit    = accept && end_of_segment && open_valid;
      end_rec.unit_address = OUT_W'(open_addr);
      end_rec.unit_size    = OUT_W'(ADDR_BITS'(seg_len - open_addr));
      end_rec.intra_flag   = open_intra;
      end_rec.region       = region;
      end_rec.final_rec    = 1'b1;

      push.count  = {1'b0, close_hit} + {1'b0, end_hit};
      push.first  = close_hit ? close_rec : end_rec;
      push.second = end_rec;

      window_in     = window_ff;
      pos_in        = pos_ff;
      pend_addr_in  = pend_addr_ff;
      pend_intra_in = pend_intra_ff;
      pend_valid_in = pend_valid_ff;
      if (accept) begin
         if (end_of_segment) begin
            window_in     = WINDOW_RESET;
            pos_in        = '0;
            pend_addr_in  = '0;
            pend_intra_in = 1'b0;
            pend_valid_in = 1'b0;
         end else begin
            window_in     = {window_ff[23:0], data_byte};
            pos_in        = seg_len;
            pend_addr_in  = open_addr;
            pend_intra_in = open_intra;
            pend_valid_in = open_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= WINDOW_RESET;
         pos_ff        <= '0;
         pend_addr_ff  <= '0;
         pend_intra_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         window_ff     <= window_in;
         pos_ff        <= pos_in;
         pend_addr_ff  <= pend_addr_in;
         pend_intra_ff <= pend_intra_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_segment |=> !pend_valid_ff && (pos_ff == '0))
      else $error("segment end did not clear the open record");

   a_two_order: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.second.final_rec && !push.first.final_rec)
      else $error("two records in wrong order");

   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> accept)
      else $error("record produced without an accepted request");

endmodule

// ----- design/hnbs_queue.sv -----
// Small record queue that decouples the scanner from the response channel.
// Depends on hnbs_pkg for the record types and queue sizing.
module hnbs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  hnbs_pkg::push_type   push,
   input  logic                 pop,
   output hnbs_pkg::record_type head,
   output logic                 not_empty,
   output logic                 has_room
);
   import hnbs_pkg::*;

   record_type        mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_pop;

   always_comb begin
      not_empty = (cnt_ff != '0);
      has_room  = (cnt_ff <= QCNT_W'(QUEUE_DEPTH - 2));
      head      = mem[rd_ptr_ff];
      do_pop    = pop && not_empty;
      wr_ptr_in = QPTR_W'(wr_ptr_ff + QPTR_W'(push.count));
      rd_ptr_in = QPTR_W'(rd_ptr_ff + QPTR_W'(do_pop));
      cnt_in    = QCNT_W'(cnt_ff + QCNT_W'(push.count) - QCNT_W'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[QPTR_W'(wr_ptr_ff + 1'b1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> has_room)
      else $error("record pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_idle_stays_empty: assert property (@(posedge clock) disable iff (reset)
      !not_empty && push.count == 2'd0 |=> !not_empty)
      else $error("queue became non-empty without a push");

endmodule

// ----- design/hevc_nal_boundary_scanner_core.sv -----
// Top level of the HEVC Annex B NAL boundary scanner.
// Depends on hnbs_pkg, hnbs_scan and hnbs_queue.
//
// Usage:
// The request channel carries one byte of an Annex B stream per request,
// with req_end_of_segment marking the final byte of a segment. The scanner
// looks for 00 00 01 start codes; a VPS header opens an intra record and a
// trailing, TSA, STSA, RADL or RASL header opens a non-intra record. Each
// new record closes the open one, and the segment's last byte closes the
// record still open. Every closed record leaves on the response channel
// with its start address, size, intra flag, region tag and final flag.
// Latency: a record caused by a request is offered on rsp_valid in the
// cycle after that request is accepted when no earlier record is waiting.
// Throughput: one byte per cycle while req_ready is high.
// A header byte that ends a segment with a record open yields two records;
// they leave one per cycle while rsp_ready is high, through a four-entry
// record queue, and req_ready drops whenever the queue holds more than two.
// When the receiver stalls, records wait in the queue and req_ready falls
// once the queue nears full. Reset empties the queue, clears the open
// record, returns the byte offset to zero and sets the region tag to zero.
// csr_wr_en writes the region tag; users must write it while idle (not enforced).
module hevc_nal_boundary_scanner_core #(
   parameter int ADDR_BITS = hnbs_pkg::ADDR_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_end_of_segment,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [hnbs_pkg::OUT_W-1:0] rsp_unit_address,
   output logic [hnbs_pkg::OUT_W-1:0] rsp_unit_size,
   output logic                       rsp_intra_flag,
   output logic [1:0]                 rsp_region,
   output logic                       rsp_final_record,
   input  logic                       csr_wr_en,
   input  logic [1:0]                 csr_wr_data
);
   import hnbs_pkg::*;

   logic [1:0] region_ff, region_in;
   logic       req_accept;
   push_type   push;
   record_type head;

   // Region tag register, copied onto each record as it is formed.
   always_comb begin
      region_in = csr_wr_en ? csr_wr_data : region_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff <= 2'd0;
      end else begin
         region_ff <= region_in;
      end
   end

   assign req_accept = req_valid && req_ready;

   hnbs_scan #(
      .ADDR_BITS(ADDR_BITS)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .data_byte      (req_data_byte),
      .end_of_segment (req_end_of_segment),
      .region         (region_ff),
      .push           (push)
   );

   hnbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_ready),
      .head      (head),
      .not_empty (rsp_valid),
      .has_room  (req_ready)
   );

   assign rsp_unit_address = head.unit_address;
   assign rsp_unit_size    = head.unit_size;
   assign rsp_intra_flag   = head.intra_flag;
   assign rsp_region       = head.region;
   assign rsp_final_record = head.final_rec;

   a_pair_only_at_end: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> req_end_of_segment)
      else $error("two records from a byte that does not end the segment");

   a_push_shows_next: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |=> rsp_valid)
      else $error("record not offered after it was formed");

   a_region_copied: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> push.first.region == region_ff)
      else $error("record carries a stale region tag");

endmodule

// ----- verif/hevc_nal_boundary_scanner_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for hevc_nal_boundary_scanner_core: directed bytes, then random
// Annex B segments under varying back-pressure. Depends on hnbs_pkg and the design files.
module hevc_nal_boundary_scanner_core_tb;
   import hnbs_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_segment = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_unit_address;
   logic [31:0] rsp_unit_size;
   logic        rsp_intra_flag;
   logic [1:0]  rsp_region;
   logic        rsp_final_record;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = 2'd0;

   hevc_nal_boundary_scanner_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_segment (req_end_of_segment),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_unit_address   (rsp_unit_address),
      .rsp_unit_size      (rsp_unit_size),
      .rsp_intra_flag     (rsp_intra_flag),
      .rsp_region         (rsp_region),
      .rsp_final_record   (rsp_final_record),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Scanner state as the testbench sees it, updated on every accepted request.
   logic [31:0] scan_window;
   logic [31:0] scan_offset;
   logic [31:0] open_address;
   logic        open_intra;
   logic        open_valid;
   logic [1:0]  region_model = 2'd0;
   record_type  expected_records[$];

   int error_count     = 0;
   int bytes_sent      = 0;
   int segments_sent   = 0;
   int records_checked = 0;
   int records_queued  = 0;
   int intra_seen      = 0;
   int final_seen      = 0;
   int cycle_count     = 0;
   int send_idle_pct   = 17;
   int recv_idle_pct   = 71;
   int hold_requests   = 0;
   int holds_served    = 0;
   int hold_left       = 0;

   task automatic reset_scan();
      scan_window  = WINDOW_RESET;
      scan_offset  = '0;
      open_address = '0;
      open_intra   = 1'b0;
      open_valid   = 1'b0;
   endtask

   task automatic queue_record(input logic [31:0] addr, input logic [31:0] size,
                               input logic intra, input logic fin);
      record_type rec;
      rec.unit_address = addr;
      rec.unit_size    = size;
      rec.intra_flag   = intra;
      rec.region       = region_model;
      rec.final_rec    = fin;
      expected_records.push_back(rec);
      records_queued++;
   endtask

   // Works out the records closed by one byte. A qualifying header right after a
   // start code opens a record and closes the open one; the last byte of a
   // segment closes whatever is still open and starts the next segment at zero.
   task automatic predict_records(input logic [7:0] data, input logic eos);
      logic [5:0]  nal_type;
      logic [31:0] start_addr;
      if (scan_window[23:0] == START_CODE) begin
         nal_type = data[6:1];
         if (nal_type == TYPE_VPS || nal_type <= TYPE_LAST_TRAIL) begin
            // A fourth zero ahead of 00 00 01 belongs to the start code.
            start_addr = scan_offset - ((scan_window[31:24] == 8'h00) ? 32'd4 : 32'd3);
            if (open_valid)
               queue_record(open_address, start_addr - open_address, open_intra, 1'b0);
            open_address = start_addr;
            open_intra   = (nal_type == TYPE_VPS);
            open_valid   = 1'b1;
         end
      end
      if (eos) begin
         if (open_valid)
            queue_record(open_address, scan_offset + 32'd1 - open_address, open_intra, 1'b1);
         reset_scan();
      end else begin
         scan_window = {scan_window[23:0], data};
         scan_offset = scan_offset + 32'd1;
      end
   endtask

   // Offers one request and waits for it to be taken. The valid line is only
   // lowered when a gap is inserted, so a back-to-back request keeps it high.
   task automatic push_byte(input logic [7:0] data, input logic eos);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= data;
      req_end_of_segment <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      predict_records(data, eos);
   endtask

   // Drops valid, waits for every record, then keeps waiting, since a byte
   // that closes nothing may still be inside the block.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_region(input logic [1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      region_model = value;
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [7:0] header_byte();
      int pick;
      logic [5:0] nal_type;
      pick = $urandom_range(9);
      if (pick < 3)
         nal_type = TYPE_VPS;
      else if (pick < 7)
         nal_type = 6'($urandom_range(9));
      else
         nal_type = 6'($urandom_range(63, 10));
      return {1'($urandom_range(1)), nal_type, 1'($urandom_range(1))};
   endfunction

   function automatic logic [7:0] payload_byte();
      int pick;
      pick = $urandom_range(7);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'h01;
      return 8'($urandom_range(255));
   endfunction

   // Mostly well-formed segments of start-coded units with random payloads;
   // the rest is noise. Some segments end on a bare start code or on a header.
   task automatic send_segment();
      logic [7:0] seg[$];
      int tail;
      if ($urandom_range(99) < 20) begin
         repeat ($urandom_range(24, 1)) seg.push_back(payload_byte());
      end else begin
         repeat ($urandom_range(5, 1)) begin
            if ($urandom_range(1) == 1) seg.push_back(8'h00);
            seg.push_back(8'h00);
            seg.push_back(8'h00);
            seg.push_back(8'h01);
            seg.push_back(header_byte());
            repeat ($urandom_range(10)) seg.push_back(payload_byte());
         end
         tail = $urandom_range(9);
         if (tail < 2) begin
            seg.push_back(8'h00);
            seg.push_back(8'h00);
            seg.push_back(8'h01);
            if (tail == 1) seg.push_back(header_byte());
         end
      end
      foreach (seg[i]) push_byte(seg[i], i == seg.size() - 1);
      segments_sent++;
   endtask

   task automatic run_segments(input int byte_goal);
      int first;
      first = bytes_sent;
      while (bytes_sent - first < byte_goal) send_segment();
   endtask

   typedef struct packed {
      logic [7:0]  data;
      logic        eos;
      logic        typed;
      logic [31:0] w_addr;
      logic [31:0] w_size;
      logic        w_intra;
   } opening_row_type;

   // End of segment with nothing open; a trailing unit first; a VPS behind a
   // four-byte start code; type 9 and a non-opening type 63; a header on the
   // last byte, which gives two records; a start code with no header byte.
   opening_row_type opening_bytes [0:24] = '{
      '{8'hFF, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h01, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h02, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h01, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h40, 1'b0, 1'b1, 32'd0, 32'd4, 1'b0},
      '{8'h00, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h01, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h13, 1'b0, 1'b1, 32'd4, 32'd5, 1'b1},
      '{8'h00, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h01, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'hFE, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h01, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h01, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h01, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0}
   };

   // Receiver: random stalls, plus a long hold-off whenever one is asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= LONG_HOLD;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      record_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_records.size() == 0) begin
            error_count++;
            $display("%0t: record with none expected, expected nothing, actual addr %0d size %0d",
                     $time, rsp_unit_address, rsp_unit_size);
         end else begin
            want = expected_records.pop_front();
            check_field("unit_address", want.unit_address, rsp_unit_address);
            check_field("unit_size", want.unit_size, rsp_unit_size);
            check_field("intra_flag", 32'(want.intra_flag), 32'(rsp_intra_flag));
            check_field("region", 32'(want.region), 32'(rsp_region));
            check_field("final_record", 32'(want.final_rec), 32'(rsp_final_record));
            records_checked++;
            if (rsp_intra_flag) intra_seen++;
            if (rsp_final_record) final_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d records outstanding", $time, expected_records.size());
         $display("hevc_nal_boundary_scanner_core_tb NOT OK");
         $finish;
      end
   end

   initial begin
      int depth;
      reset_scan();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed bytes at the reset region tag. Rows with a typed record
      // replace what the predictor worked out for that byte; the records it
      // added are the newest ones in the queue, whatever the checker took.
      foreach (opening_bytes[i]) begin
         depth = records_queued;
         push_byte(opening_bytes[i].data, opening_bytes[i].eos);
         if (opening_bytes[i].typed) begin
            repeat (records_queued - depth) void'(expected_records.pop_back());
            queue_record(opening_bytes[i].w_addr, opening_bytes[i].w_size,
                         opening_bytes[i].w_intra, 1'b0);
         end
      end

      settle();
      write_region(2'd3);
      run_segments(450);

      settle();
      write_region(2'd1);
      send_idle_pct = 71;
      recv_idle_pct = 17;
      run_segments(450);

      // Long receiver stall while requests keep coming, so the queue fills.
      settle();
      write_region(2'd2);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests <= hold_requests + 1;
      run_segments(120);

      settle();
      write_region(2'd0);
      run_segments(450);

      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d requests in %0d segments over four region tags and a long stall.",
               bytes_sent, segments_sent);
      $display("Checked %0d records, %0d intra and %0d closed by end of segment.",
               records_checked, intra_seen, final_seen);
      if (error_count == 0 && expected_records.size() == 0) begin
         $display("hevc_nal_boundary_scanner_core_tb OK");
      end else begin
         $display("hevc_nal_boundary_scanner_core_tb NOT OK");
      end
      $finish;
   end

endmodule
